// ===== sv/shnm_pkg.sv =====
// ----------------------------------------------------------------------------
// Scale harmony note mapper package
// Shared types, codes and the voicing table of the harmony note mapper.
// ----------------------------------------------------------------------------
package shnm_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_OCT,
        S_SEARCH,
        S_TARGET,
        S_WRAP,
        S_NOTE,
        S_ADJ,
        S_CHROM
    } state_t;

    // Voicing codes
    typedef enum logic [4:0] {
        HT_THIRD_DN          = 5'd0,
        HT_THIRD_UP          = 5'd1,
        HT_THIRD_BOTH        = 5'd2,
        HT_FOURTH_DN         = 5'd3,
        HT_FOURTH_UP         = 5'd4,
        HT_FOURTH_BOTH       = 5'd5,
        HT_FIFTH_DN          = 5'd6,
        HT_FIFTH_UP          = 5'd7,
        HT_FIFTH_BOTH        = 5'd8,
        HT_THIRD_DN_FIFTH_UP = 5'd9,
        HT_FIFTH_DN_THIRD_UP = 5'd10,
        HT_OCTAVE_DN         = 5'd11,
        HT_OCTAVE_UP         = 5'd12,
        HT_OCTAVE_BOTH       = 5'd13,
        HT_STACK3            = 5'd14,
        HT_STACK4            = 5'd15,
        HT_POWER             = 5'd16,
        HT_PARALLEL_THIRD    = 5'd17,
        HT_DRONE             = 5'd18,
        HT_UNISON2           = 5'd19,
        HT_UNISON_OCT4       = 5'd20
    } harmony_t;

    // Register indexes (byte address bits [4:3])
    localparam logic [1:0] REG_SCALE_NOTES  = 2'd0;
    localparam logic [1:0] REG_SCALE_SIZE   = 2'd1;
    localparam logic [1:0] REG_HARMONY_TYPE = 2'd2;

    localparam logic [47:0] SCALE_NOTES_RST  = 48'd0;
    localparam logic [3:0]  SCALE_SIZE_RST   = 4'd0;
    localparam logic [4:0]  HARMONY_TYPE_RST = 5'(HT_THIRD_UP);

    localparam int SCALE_SLOTS = 12;

    // Degree offset markers: one octave of degrees up or down
    typedef logic signed [4:0] off_t;
    localparam off_t DEG_UP_CODE = 5'sd15;
    localparam off_t DEG_DN_CODE = -5'sd15;

    // Floor division by twelve for values up to 128: (x * 171) >> 11
    localparam logic [7:0] RECIP12       = 8'd171;
    localparam int         RECIP12_SHIFT = 11;

    // Output saturation, in whole notes and in signed 9.8 pitch units
    localparam logic signed [9:0]  NOTE_MIN  = -10'sd16;
    localparam logic signed [9:0]  NOTE_MAX  = 10'sd159;
    localparam logic signed [16:0] PITCH_MIN = -17'sd4096;
    localparam logic signed [16:0] PITCH_MAX = 17'sd40959;

    typedef struct packed {
        logic [2:0]  count;
        off_t [3:0]  semi;
        off_t [3:0]  deg;
    } voicing_t;

    function automatic voicing_t voicing(input logic [4:0] code);
        voicing_t v;
        v = '0;
        unique case (harmony_t'(code))
            HT_THIRD_DN:
            begin
                v.count = 3'd1; v.semi[0] = -5'sd3; v.deg[0] = -5'sd2;
            end
            HT_THIRD_UP:
            begin
                v.count = 3'd1; v.semi[0] = 5'sd3; v.deg[0] = 5'sd2;
            end
            HT_THIRD_BOTH:
            begin
                v.count = 3'd2;
                v.semi[0] = -5'sd3; v.semi[1] = 5'sd3;
                v.deg[0]  = -5'sd2; v.deg[1]  = 5'sd2;
            end
            HT_FOURTH_DN:
            begin
                v.count = 3'd1; v.semi[0] = -5'sd5; v.deg[0] = -5'sd3;
            end
            HT_FOURTH_UP:
            begin
                v.count = 3'd1; v.semi[0] = 5'sd5; v.deg[0] = 5'sd3;
            end
            HT_FOURTH_BOTH:
            begin
                v.count = 3'd2;
                v.semi[0] = -5'sd5; v.semi[1] = 5'sd5;
                v.deg[0]  = -5'sd3; v.deg[1]  = 5'sd3;
            end
            HT_FIFTH_DN:
            begin
                v.count = 3'd1; v.semi[0] = -5'sd7; v.deg[0] = -5'sd4;
            end
            HT_FIFTH_UP:
            begin
                v.count = 3'd1; v.semi[0] = 5'sd7; v.deg[0] = 5'sd4;
            end
            HT_FIFTH_BOTH:
            begin
                v.count = 3'd2;
                v.semi[0] = -5'sd7; v.semi[1] = 5'sd7;
                v.deg[0]  = -5'sd4; v.deg[1]  = 5'sd4;
            end
            HT_THIRD_DN_FIFTH_UP:
            begin
                v.count = 3'd2;
                v.semi[0] = -5'sd3; v.semi[1] = 5'sd7;
                v.deg[0]  = -5'sd2; v.deg[1]  = 5'sd4;
            end
            HT_FIFTH_DN_THIRD_UP:
            begin
                v.count = 3'd2;
                v.semi[0] = -5'sd7; v.semi[1] = 5'sd3;
                v.deg[0]  = -5'sd4; v.deg[1]  = 5'sd2;
            end
            HT_OCTAVE_DN:
            begin
                v.count = 3'd1; v.semi[0] = -5'sd12; v.deg[0] = DEG_DN_CODE;
            end
            HT_OCTAVE_UP:
            begin
                v.count = 3'd1; v.semi[0] = 5'sd12; v.deg[0] = DEG_UP_CODE;
            end
            HT_OCTAVE_BOTH:
            begin
                v.count = 3'd2;
                v.semi[0] = -5'sd12;     v.semi[1] = 5'sd12;
                v.deg[0]  = DEG_DN_CODE; v.deg[1]  = DEG_UP_CODE;
            end
            HT_STACK3:
            begin
                v.count = 3'd3;
                v.semi[0] = 5'sd3; v.semi[1] = 5'sd7; v.semi[2] = 5'sd12;
                v.deg[0]  = 5'sd2; v.deg[1]  = 5'sd4; v.deg[2]  = DEG_UP_CODE;
            end
            HT_STACK4:
            begin
                v.count = 3'd4;
                v.semi[0] = -5'sd3; v.semi[1] = 5'sd3;
                v.semi[2] = 5'sd7;  v.semi[3] = 5'sd12;
                v.deg[0]  = -5'sd2; v.deg[1]  = 5'sd2;
                v.deg[2]  = 5'sd4;  v.deg[3]  = DEG_UP_CODE;
            end
            HT_POWER:
            begin
                v.count = 3'd2;
                v.semi[0] = 5'sd7; v.semi[1] = 5'sd12;
                v.deg[0]  = 5'sd4; v.deg[1]  = DEG_UP_CODE;
            end
            HT_PARALLEL_THIRD:
            begin
                v.count = 3'd1; v.semi[0] = 5'sd3; v.deg[0] = 5'sd1;
            end
            HT_DRONE:
            begin
                v.count = 3'd1; v.semi[0] = 5'sd0; v.deg[0] = DEG_DN_CODE;
            end
            HT_UNISON2:
            begin
                v.count = 3'd2;
            end
            HT_UNISON_OCT4:
            begin
                v.count = 3'd4;
                v.semi[2] = -5'sd12;     v.semi[3] = 5'sd12;
                v.deg[2]  = DEG_DN_CODE; v.deg[3]  = DEG_UP_CODE;
            end
            default:
            begin
                v = '0;
            end
        endcase
        return v;
    endfunction

endpackage

// ===== sv/scale_harmony_note_mapper_core.sv =====
// ----------------------------------------------------------------------------
// Scale harmony note mapper core
// Maps one detected pitch to up to four harmony pitches, scale aware.
// ----------------------------------------------------------------------------
// Usage:
//   Configure scale_notes (byte address 0), scale_size (8) and harmony_type
//   (16) over the APB port while the block is idle; pready is always high.
//   Pulse start with pitch_valid and pitch while busy is low to hand over an
//   item. Results appear one per cycle or slower on harmony_pitch/last_note,
//   each marked by a one-cycle result_valid pulse; the receiver cannot stall,
//   so it must take every pulse. last_note marks the final result.
//   An invalid pitch or an unused voicing code is dropped with no result
//   and busy stays low.
// Timing:
//   Chromatic mode (scale_size 0): one result per cycle, one per voice.
//   Scale mode: one shared adder steps the sequencer. The rounded note is taken
//   at acceptance, S_OCT finds octave and remainder, S_SEARCH runs the
//   nearest-degree search over n degrees (n = scale size, at most MAX_SCALE),
//   then per voice S_TARGET resolves the degree, S_WRAP steps it modulo n
//   (up to four steps and a settle check), S_NOTE forms the note and S_ADJ
//   pulls it by octaves, then issues the result. Each strobe follows its
//   issuing cycle.
// Reset: rst_n clears the sequencer and loads the register defaults.
// ----------------------------------------------------------------------------
module scale_harmony_note_mapper_core #(
    parameter int MAX_SCALE = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    // item in
    input  logic               start,
    output logic               busy,
    input  logic               pitch_valid,
    input  logic [14:0]        pitch,
    // results out
    output logic               result_valid,
    output logic signed [16:0] harmony_pitch,
    output logic               last_note
);

    // Configuration registers
    logic [47:0] scale_notes_reg;
    logic [3:0]  scale_size_reg;
    logic [4:0]  harmony_type_reg;
    logic        cfg_write;

    // Sequencer and working registers
    shnm_pkg::state_t state_reg, state_next;
    logic [14:0]        pitch_reg, pitch_next;
    logic [7:0]         base_reg, base_next;
    logic [7:0]         oct12_reg, oct12_next;
    logic [3:0]         rem_reg, rem_next;
    logic [3:0]         deg_reg, deg_next;
    logic [3:0]         best_deg_reg, best_deg_next;
    logic [2:0]         best_dist_reg, best_dist_next;
    logic signed [9:0]  best_note_reg, best_note_next;
    logic [1:0]         voice_reg, voice_next;
    shnm_pkg::off_t     off_reg, off_next;
    logic signed [5:0]  wrap_reg, wrap_next;
    logic signed [3:0]  shift_reg, shift_next;
    logic signed [9:0]  note_reg, note_next;

    // Result registers
    logic               res_valid_reg, res_valid_next;
    logic signed [16:0] res_pitch_reg, res_pitch_next;
    logic               res_last_reg, res_last_next;

    // Shared adder
    logic signed [9:0] alu_a, alu_b, alu_sum;

    logic [3:0]         n_eff;
    shnm_pkg::voicing_t vc;
    logic               accept;
    logic               last_voice;
    logic [3:0]         cls_idx, cls;
    logic [15:0]        base_sum;
    logic [15:0]        oct_prod;
    logic [3:0]         oct_q;
    logic [7:0]         oct12_q;
    logic signed [9:0]  delta;
    logic [2:0]         deg_gap;
    shnm_pkg::off_t     off_code, off_res;
    logic signed [5:0]  target;
    logic               wrap_neg, wrap_hi;
    logic signed [9:0]  base_s, shift_s, shift12, note_diff;
    logic               adj_need, adj_up;
    shnm_pkg::off_t     semi;
    logic signed [16:0] chrom_pitch;
    logic signed [16:0] sat_pitch;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign busy      = (state_reg != shnm_pkg::S_IDLE);
    assign accept    = start && !busy;

    assign result_valid  = res_valid_reg;
    assign harmony_pitch = res_pitch_reg;
    assign last_note     = res_last_reg;

    // Oversized scales act as MAX_SCALE
    assign n_eff = (scale_size_reg > 4'(MAX_SCALE)) ? 4'(MAX_SCALE) : scale_size_reg;
    assign vc    = shnm_pkg::voicing(harmony_type_reg);
    assign last_voice = ({1'b0, voice_reg} == (vc.count - 3'd1));

    // ------------------------------------------------------------------
    // Configuration write and read-back
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_notes_reg  <= shnm_pkg::SCALE_NOTES_RST;
            scale_size_reg   <= shnm_pkg::SCALE_SIZE_RST;
            harmony_type_reg <= shnm_pkg::HARMONY_TYPE_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:3])
                shnm_pkg::REG_SCALE_NOTES:  scale_notes_reg  <= pwdata[47:0];
                shnm_pkg::REG_SCALE_SIZE:   scale_size_reg   <= pwdata[3:0];
                shnm_pkg::REG_HARMONY_TYPE: harmony_type_reg <= pwdata[4:0];
                default:
                begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            shnm_pkg::REG_SCALE_NOTES:  prdata = {16'd0, scale_notes_reg};
            shnm_pkg::REG_SCALE_SIZE:   prdata = {60'd0, scale_size_reg};
            shnm_pkg::REG_HARMONY_TYPE: prdata = {59'd0, harmony_type_reg};
            default:                    prdata = 64'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Scale class lookup: one read port, address chosen by state
    // ------------------------------------------------------------------
    assign cls_idx = (state_reg == shnm_pkg::S_SEARCH) ? deg_reg : wrap_reg[3:0];

    always_comb
    begin
        cls = 4'd0;
        for (int k = 0; k < shnm_pkg::SCALE_SLOTS; k++)
        begin
            if (cls_idx == 4'(k))
            begin
                cls = scale_notes_reg[4*k +: 4];
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared adder operand selection
    // ------------------------------------------------------------------
    assign wrap_neg = wrap_reg[5];
    assign wrap_hi  = !wrap_neg && (wrap_reg >= $signed({2'b00, n_eff}));

    assign base_s    = $signed({2'b00, base_reg});
    assign note_diff = note_reg - best_note_reg;

    // Octave pull decision for the current voice
    always_comb
    begin
        adj_need = 1'b0;
        adj_up   = 1'b0;
        if (off_reg > 5'sd0)
        begin
            adj_need = (note_reg < (base_s - 10'sd1));
            adj_up   = 1'b1;
        end
        else if (off_reg < 5'sd0)
        begin
            adj_need = (note_reg > (base_s + 10'sd1));
        end
        else
        begin
            adj_need = (note_diff > 10'sd6) || (note_diff < -10'sd6);
            adj_up   = (note_diff < -10'sd6);
        end
    end

    always_comb
    begin
        alu_a = 10'sd0;
        alu_b = 10'sd0;
        unique case (state_reg)
            shnm_pkg::S_SEARCH:
            begin
                alu_a = $signed({6'd0, cls});
                alu_b = -$signed({6'd0, rem_reg});
            end
            shnm_pkg::S_WRAP:
            begin
                alu_a = {{4{wrap_reg[5]}}, wrap_reg};
                alu_b = wrap_neg ? $signed({6'd0, n_eff}) : -$signed({6'd0, n_eff});
            end
            shnm_pkg::S_ADJ:
            begin
                alu_a = note_reg;
                alu_b = adj_up ? 10'sd12 : -10'sd12;
            end
            default:
            begin
                alu_a = 10'sd0;
                alu_b = 10'sd0;
            end
        endcase
    end

    assign alu_sum = alu_a + alu_b;

    // ------------------------------------------------------------------
    // Per-state helpers
    // ------------------------------------------------------------------
    assign base_sum = {1'b0, pitch} + 16'd128;
    assign oct_prod = base_reg * shnm_pkg::RECIP12;
    assign oct_q    = oct_prod[shnm_pkg::RECIP12_SHIFT +: 4];
    assign oct12_q  = {1'b0, oct_q, 3'b000} + {2'b00, oct_q, 2'b00};

    // Fold class - remainder into -6..6
    always_comb
    begin
        if (alu_sum > 10'sd6)
        begin
            delta = alu_sum - 10'sd12;
        end
        else if (alu_sum < -10'sd6)
        begin
            delta = alu_sum + 10'sd12;
        end
        else
        begin
            delta = alu_sum;
        end
    end
    assign deg_gap = delta[9] ? 3'(-delta) : 3'(delta);

    // Resolve octave markers to plus or minus the scale size
    assign off_code = vc.deg[voice_reg];
    always_comb
    begin
        if (off_code == shnm_pkg::DEG_UP_CODE)
        begin
            off_res = $signed({1'b0, n_eff});
        end
        else if (off_code == shnm_pkg::DEG_DN_CODE)
        begin
            off_res = -$signed({1'b0, n_eff});
        end
        else
        begin
            off_res = off_code;
        end
    end
    assign target = $signed({2'b00, best_deg_reg}) + {off_res[4], off_res};

    assign shift_s = {{6{shift_reg[3]}}, shift_reg};
    assign shift12 = (shift_s <<< 3) + (shift_s <<< 2);

    assign semi        = vc.semi[voice_reg];
    assign chrom_pitch = $signed({2'b00, pitch_reg}) + $signed({{4{semi[4]}}, semi, 8'h00});

    always_comb
    begin
        if (note_reg < shnm_pkg::NOTE_MIN)
        begin
            sat_pitch = shnm_pkg::PITCH_MIN;
        end
        else if (note_reg > shnm_pkg::NOTE_MAX)
        begin
            sat_pitch = shnm_pkg::PITCH_MAX;
        end
        else
        begin
            sat_pitch = {note_reg[8:0], 8'h00};
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        pitch_next     = pitch_reg;
        base_next      = base_reg;
        oct12_next     = oct12_reg;
        rem_next       = rem_reg;
        deg_next       = deg_reg;
        best_deg_next  = best_deg_reg;
        best_dist_next = best_dist_reg;
        best_note_next = best_note_reg;
        voice_next     = voice_reg;
        off_next       = off_reg;
        wrap_next      = wrap_reg;
        shift_next     = shift_reg;
        note_next      = note_reg;
        res_valid_next = 1'b0;
        res_pitch_next = res_pitch_reg;
        res_last_next  = res_last_reg;

        unique case (state_reg)
            shnm_pkg::S_IDLE:
            begin
                // drop invalid pitches and unused voicing codes
                if (accept && pitch_valid &&
                    (harmony_type_reg <= 5'(shnm_pkg::HT_UNISON_OCT4)))
                begin
                    pitch_next = pitch;
                    voice_next = 2'd0;
                    base_next  = base_sum[15:8];
                    state_next = (n_eff == 4'd0) ? shnm_pkg::S_CHROM : shnm_pkg::S_OCT;
                end
            end
            shnm_pkg::S_OCT:
            begin
                oct12_next     = oct12_q;
                rem_next       = 4'(base_reg - oct12_q);
                deg_next       = 4'd0;
                best_deg_next  = 4'd0;
                best_dist_next = 3'd7;
                best_note_next = base_s;
                state_next     = shnm_pkg::S_SEARCH;
            end
            shnm_pkg::S_SEARCH:
            begin
                // strict compare: the lowest degree keeps a tie
                if (deg_gap < best_dist_reg)
                begin
                    best_dist_next = deg_gap;
                    best_deg_next  = deg_reg;
                    best_note_next = base_s + delta;
                end
                deg_next = deg_reg + 4'd1;
                if (deg_reg == (n_eff - 4'd1))
                begin
                    voice_next = 2'd0;
                    state_next = shnm_pkg::S_TARGET;
                end
            end
            shnm_pkg::S_TARGET:
            begin
                off_next   = off_res;
                wrap_next  = target;
                shift_next = 4'sd0;
                state_next = shnm_pkg::S_WRAP;
            end
            shnm_pkg::S_WRAP:
            begin
                // step the degree into 0..n-1, counting octaves
                if (wrap_neg)
                begin
                    wrap_next  = alu_sum[5:0];
                    shift_next = shift_reg - 4'sd1;
                end
                else if (wrap_hi)
                begin
                    wrap_next  = alu_sum[5:0];
                    shift_next = shift_reg + 4'sd1;
                end
                else
                begin
                    state_next = shnm_pkg::S_NOTE;
                end
            end
            shnm_pkg::S_NOTE:
            begin
                note_next  = $signed({2'b00, oct12_reg}) + $signed({6'd0, cls}) + shift12;
                state_next = shnm_pkg::S_ADJ;
            end
            shnm_pkg::S_ADJ:
            begin
                if (adj_need)
                begin
                    note_next = alu_sum;
                end
                else
                begin
                    res_valid_next = 1'b1;
                    res_pitch_next = sat_pitch;
                    res_last_next  = last_voice;
                    voice_next     = voice_reg + 2'd1;
                    state_next     = last_voice ? shnm_pkg::S_IDLE : shnm_pkg::S_TARGET;
                end
            end
            shnm_pkg::S_CHROM:
            begin
                // fixed semitone offsets, fraction kept
                res_valid_next = 1'b1;
                res_pitch_next = chrom_pitch;
                res_last_next  = last_voice;
                voice_next     = voice_reg + 2'd1;
                if (last_voice)
                begin
                    state_next = shnm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = shnm_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shnm_pkg::S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        pitch_reg     <= pitch_next;
        base_reg      <= base_next;
        oct12_reg     <= oct12_next;
        rem_reg       <= rem_next;
        deg_reg       <= deg_next;
        best_deg_reg  <= best_deg_next;
        best_dist_reg <= best_dist_next;
        best_note_reg <= best_note_next;
        voice_reg     <= voice_next;
        off_reg       <= off_next;
        wrap_reg      <= wrap_next;
        shift_reg     <= shift_next;
        note_reg      <= note_next;
        res_pitch_reg <= res_pitch_next;
        res_last_reg  <= res_last_next;
    end

endmodule

// ===== sv/shnm_checker.sv =====
// ----------------------------------------------------------------------------
// Scale harmony note mapper checker
// Port-level checks on the item and result channels, bound to the core.
// ----------------------------------------------------------------------------
module shnm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               pitch_valid,
    input logic               result_valid,
    input logic signed [16:0] harmony_pitch,
    input logic               last_note
);

    // A result only follows a busy cycle
    a_result_after_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy)
    ) else $error("result without work in progress");

    // The final result frees the block, earlier ones keep it busy
    a_last_frees: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> (last_note == !busy)
    ) else $error("last flag and busy disagree");

    // An invalid pitch is dropped with no result
    a_invalid_dropped: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy && !pitch_valid) |=> (!busy && !result_valid)
    ) else $error("invalid pitch produced work");

    // Results stay within the saturation range
    a_pitch_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid |-> ((harmony_pitch >= shnm_pkg::PITCH_MIN) &&
                          (harmony_pitch <= shnm_pkg::PITCH_MAX))
    ) else $error("harmony pitch out of range");

endmodule

bind scale_harmony_note_mapper_core shnm_checker u_shnm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .pitch_valid   (pitch_valid),
    .result_valid  (result_valid),
    .harmony_pitch (harmony_pitch),
    .last_note     (last_note)
);
